// ----- rtl/core/assert_macros.svh -----
// assertion macros for the directory rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted (active low)
`define LBCD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lbcd assertion failed");

// clocked check that also holds during reset
`define LBCD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lbcd assertion failed");

`endif

// ----- rtl/core/lbcd_pkg.sv -----
// shared types and constants of the buffer cache directory
package lbcd_pkg;

  localparam int ENTRIES   = 32;
  localparam int DISK_SIZE = 8192;
  localparam int AGE_BITS  = 16;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int BLK_W = $clog2(DISK_SIZE);
  localparam int IN_BLK_W = 16;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_MARK   = 2'd2,
    ACT_RSVD   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_OOB  = 2'd1,
    STAT_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lbcd_cmd_t;

  typedef struct packed {
    logic scan_last;
  } lbcd_sts_t;

endpackage

// ----- rtl/core/lbcd_ctrl.sv -----
// sequencer: request intake, entry scan and result commit
`include "assert_macros.svh"

module lbcd_ctrl import lbcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lbcd_cmd_t cmd,
  input  lbcd_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  `LBCD_ASSERT(a_scan_ends, clk, rst_n, (state_r == S_SCAN && sts.scan_last) |=> (state_r == S_COMMIT))
  `LBCD_ASSERT(a_commit_shows, clk, rst_n, cmd.commit |=> out_valid_r)
  `LBCD_ASSERT(a_accept_scans, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_SCAN))
  `LBCD_ASSERT_ALWAYS(a_no_overwrite, clk, (cmd.commit && out_valid_r) |-> out_ready)

endmodule

// ----- rtl/core/lbcd_datapath.sv -----
// directory entries, scan tracking and result register
module lbcd_datapath import lbcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lbcd_cmd_t           cmd,
  output lbcd_sts_t           sts,
  input  logic [1:0]          in_action,
  input  logic [IN_BLK_W-1:0] in_block_number,
  output logic [1:0]          out_status,
  output logic [IDX_W-1:0]    out_entry_index,
  output logic                out_writeback_valid,
  output logic [BLK_W-1:0]    out_writeback_block
);

  logic [ENTRIES-1:0]  occupied_r;
  logic [ENTRIES-1:0]  dirty_r;
  logic [BLK_W-1:0]    cached_r [ENTRIES];
  logic [AGE_BITS-1:0] age_r    [ENTRIES];

  action_t             act_r;
  logic [BLK_W-1:0]    blk_r;
  logic                oob_r;
  logic [IDX_W-1:0]    idx_r;
  logic                found_r;
  logic [IDX_W-1:0]    pick_r;
  logic [AGE_BITS-1:0] best_age_r;
  logic                wb_r;
  logic [BLK_W-1:0]    wb_blk_r;

  logic [1:0]          status_r;
  logic [IDX_W-1:0]    index_r;
  logic                wbv_r;
  logic [BLK_W-1:0]    wbb_r;

  logic                is_alloc;
  logic                cur_occ;
  logic [AGE_BITS-1:0] cur_age;
  logic [AGE_BITS-1:0] aged;

  assign is_alloc = (act_r == ACT_ALLOC);
  assign cur_occ  = occupied_r[idx_r];
  assign cur_age  = age_r[idx_r];
  assign aged     = (cur_occ && cur_age != AGE_MAX) ? cur_age + AGE_BITS'(1) : cur_age;
  assign sts.scan_last = (idx_r == IDX_W'(ENTRIES - 1));

  // occupancy is the only entry state that needs a reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occupied_r <= '0;
    end else if (cmd.commit && is_alloc && !oob_r) begin
      occupied_r[pick_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && is_alloc && !oob_r) begin
      age_r[idx_r] <= aged;
    end
    if (cmd.commit && !oob_r) begin
      if (is_alloc) begin
        dirty_r[pick_r]  <= 1'b0;
        cached_r[pick_r] <= blk_r;
        age_r[pick_r]    <= '0;
      end else if (act_r == ACT_MARK && found_r) begin
        dirty_r[pick_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= action_t'(in_action);
      blk_r   <= in_block_number[BLK_W-1:0];
      oob_r   <= (32'(in_block_number) >= DISK_SIZE);
      idx_r   <= '0;
      found_r <= 1'b0;
      pick_r  <= '0;
      wb_r    <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (!found_r) begin
        if (is_alloc) begin
          if (!cur_occ) begin
            found_r <= 1'b1;
            pick_r  <= idx_r;
            wb_r    <= 1'b0;
          end else if (idx_r == '0 || aged > best_age_r) begin
            pick_r     <= idx_r;
            best_age_r <= aged;
            wb_r       <= dirty_r[idx_r];
            wb_blk_r   <= cached_r[idx_r];
          end
        end else if (cur_occ && cached_r[idx_r] == blk_r) begin
          found_r <= 1'b1;
          pick_r  <= idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= STAT_OK;
      index_r  <= '0;
      wbv_r    <= 1'b0;
      wbb_r    <= '0;
      if (oob_r) begin
        status_r <= STAT_OOB;
      end else if (is_alloc) begin
        index_r <= pick_r;
        wbv_r   <= wb_r;
        wbb_r   <= wb_r ? wb_blk_r : '0;
      end else if (found_r) begin
        index_r <= pick_r;
      end else begin
        status_r <= STAT_MISS;
      end
    end
  end

  assign out_status          = status_r;
  assign out_entry_index     = index_r;
  assign out_writeback_valid = wbv_r;
  assign out_writeback_block = wbb_r;

endmodule

// ----- rtl/core/lru_buffer_cache_directory.sv -----
// top level of the lru buffer cache directory
// Directory of a disk block buffer cache with ENTRIES (32) entries. Each request word
// (action, block_number) yields exactly one result word. A request holds the block from
// the idle state in which the word is taken, through the scan of every entry (one entry
// read, and on allocate aged, per cycle through a single scan counter), to the commit
// state that writes the chosen entry and loads the output register. No new request is
// taken until the previous one has been committed. Allocate ages occupied entries, then
// takes the lowest free entry or else the oldest (lowest index on ties); a dirty victim
// is reported on out_writeback_valid and out_writeback_block. Look-up, mark-dirty
// and the spare action code return the lowest matching entry. Block numbers at or above
// DISK_SIZE give status out of bound and leave the directory untouched. A new request
// can be taken while the previous result waits on out_ready; its commit cycle then
// stretches until that result is taken.
module lru_buffer_cache_directory import lbcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [IN_BLK_W-1:0] in_block_number,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [IDX_W-1:0]    out_entry_index,
  output logic                out_writeback_valid,
  output logic [BLK_W-1:0]    out_writeback_block
);

  // commands from the sequencer, scan status back
  lbcd_cmd_t cmd;
  lbcd_sts_t sts;

  // sequencer: idle, scan, commit
  lbcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // entry storage, victim tracking and output register
  lbcd_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_action           (in_action),
    .in_block_number     (in_block_number),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_block (out_writeback_block)
  );

endmodule

// ----- tb/lbcd_checker.sv -----
// directory checker: predicts every result word and compares it with the block's output
module lbcd_checker import lbcd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [IN_BLK_W-1:0] in_block_number,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [1:0]          out_status,
  input  logic [IDX_W-1:0]    out_entry_index,
  input  logic                out_writeback_valid,
  input  logic [BLK_W-1:0]    out_writeback_block,
  output int                  fail_count,
  output int                  words_pending,
  output int                  words_in,
  output int                  allocs,
  output int                  writebacks,
  output int                  misses,
  output int                  out_of_bound
);

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] idx;
    logic             wb_valid;
    logic [BLK_W-1:0] wb_block;
  } dir_result_t;

  // shadow copy of the directory
  bit                  occupied [ENTRIES];
  bit                  dirty [ENTRIES];
  logic [BLK_W-1:0]    cached_block [ENTRIES];
  logic [AGE_BITS-1:0] age [ENTRIES];

  dir_result_t expected_results [$];

  function automatic dir_result_t apply_request(logic [1:0] act, logic [IN_BLK_W-1:0] blk);
    dir_result_t r;
    int pick;
    r = '0;
    if (blk >= DISK_SIZE) begin
      r.status = STAT_OOB;
      return r;
    end
    if (act == ACT_ALLOC) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (occupied[i] && age[i] != AGE_MAX) age[i] = age[i] + 1'b1;
      end
      pick = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (pick < 0 && !occupied[i]) pick = i;
      end
      // full: oldest wins, lowest index on ties
      if (pick < 0) begin
        pick = 0;
        for (int i = 1; i < ENTRIES; i++) begin
          if (age[i] > age[pick]) pick = i;
        end
      end
      if (occupied[pick] && dirty[pick]) begin
        r.wb_valid = 1'b1;
        r.wb_block = cached_block[pick];
      end
      occupied[pick]     = 1'b1;
      dirty[pick]        = 1'b0;
      cached_block[pick] = blk[BLK_W-1:0];
      age[pick]          = '0;
      r.status = STAT_OK;
      r.idx    = pick[IDX_W-1:0];
      return r;
    end
    // look-up, mark and the spare code all search for the lowest match
    pick = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (pick < 0 && occupied[i] && cached_block[i] == blk[BLK_W-1:0]) pick = i;
    end
    if (pick < 0) begin
      r.status = STAT_MISS;
      return r;
    end
    if (act == ACT_MARK) dirty[pick] = 1'b1;
    r.status = STAT_OK;
    r.idx    = pick[IDX_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    dir_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        occupied[i]     = 1'b0;
        dirty[i]        = 1'b0;
        cached_block[i] = '0;
        age[i]          = '0;
      end
      expected_results.delete();
      fail_count   = 0;
      words_in     = 0;
      allocs       = 0;
      writebacks   = 0;
      misses       = 0;
      out_of_bound = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected, status %0d index %0d",
                   $time, out_status, out_entry_index);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("entry_index", want.idx, out_entry_index);
          check_field("writeback_valid", want.wb_valid, out_writeback_valid);
          check_field("writeback_block", want.wb_block, out_writeback_block);
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(in_action, in_block_number);
        expected_results.push_back(want);
        words_in++;
        if (want.status == STAT_OOB) out_of_bound++;
        if (want.status == STAT_MISS) misses++;
        if (want.status == STAT_OK && in_action == ACT_ALLOC) allocs++;
        if (want.wb_valid) writebacks++;
      end
    end
    words_pending = expected_results.size();
  end

endmodule

// ----- tb/lru_buffer_cache_directory_tb.sv -----
// testbench top: request stimulus, result-side flow control, watchdog and verdict
module lru_buffer_cache_directory_tb;
  import lbcd_pkg::*;

  localparam int HOLD_OFF_CYCLES  = 300;   // long result stall, fills the block
  localparam int STALL_LIMIT      = 3000;  // cycles with no word moving before giving up
  localparam int TAIL_CYCLES      = 40;    // tail wait, longer than one request takes through the block
  localparam int RANDOM_PER_PHASE = 317;
  localparam int POOL_DEPTH       = 40;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_action;
  logic [IN_BLK_W-1:0] in_block_number;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          out_status;
  logic [IDX_W-1:0]    out_entry_index;
  logic                out_writeback_valid;
  logic [BLK_W-1:0]    out_writeback_block;

  int fail_count;
  int words_pending;
  int words_in;
  int allocs;
  int writebacks;
  int misses;
  int out_of_bound;

  // idling percentages per phase, and the receiver hold-off request
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int idle_cycles;

  // blocks allocated lately, so look-ups and marks mostly hit
  logic [IN_BLK_W-1:0] recent_blocks [$];

  always #10 clk = ~clk;

  lru_buffer_cache_directory u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_block (out_writeback_block)
  );

  lbcd_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_block_number     (in_block_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_entry_index     (out_entry_index),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_block (out_writeback_block),
    .fail_count          (fail_count),
    .words_pending       (words_pending),
    .words_in            (words_in),
    .allocs              (allocs),
    .writebacks          (writebacks),
    .misses              (misses),
    .out_of_bound        (out_of_bound)
  );

  // result side: random back-pressure, or a counted hold-off when asked for
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: counts cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one request word; returns at the edge where it is taken, valid still high
  // so a back-to-back word does not lower and raise it in one step
  task automatic send_word(input logic [1:0] act, input logic [IN_BLK_W-1:0] blk);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_block_number <= blk;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_ALLOC && blk < DISK_SIZE) begin
      recent_blocks.push_back(blk);
      if (recent_blocks.size() > POOL_DEPTH) void'(recent_blocks.pop_front());
    end
  endtask

  // random word: allocations, look-ups and marks, mostly on recent blocks, some noise
  task automatic send_random_word();
    logic [1:0]          act;
    logic [IN_BLK_W-1:0] blk;
    int                  roll;
    roll = $urandom_range(0, 99);
    if (roll < 40)      act = ACT_ALLOC;
    else if (roll < 65) act = ACT_LOOKUP;
    else if (roll < 90) act = ACT_MARK;
    else                act = ACT_RSVD;
    roll = $urandom_range(0, 99);
    if (roll < 55 && recent_blocks.size() > 0)
      blk = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
    else if (roll < 70)
      blk = IN_BLK_W'($urandom_range(0, 47));           // small range gives duplicates
    else if (roll < 90)
      blk = IN_BLK_W'($urandom_range(0, DISK_SIZE - 1));
    else
      blk = IN_BLK_W'($urandom_range(DISK_SIZE, 65535)); // out of bound, high bits set
    send_word(act, blk);
  endtask

  // sender pause: drop valid and wait for every outstanding result
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_action       = ACT_ALLOC;
    in_block_number = '0;
    hold_req        = 1'b0;
    hold_left       = 0;
    idle_cycles     = 0;
    send_idle_pct   = 7;
    recv_idle_pct   = 78;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // out of bound for every action code, state must stay empty
    send_word(ACT_ALLOC, 16'd8192);
    send_word(ACT_LOOKUP, 16'hFFFF);
    send_word(ACT_MARK, 16'hFFFF);
    send_word(ACT_RSVD, 16'd8192);
    // misses on an empty directory
    send_word(ACT_LOOKUP, 16'd0);
    send_word(ACT_MARK, 16'd5);
    send_word(ACT_RSVD, 16'd0);
    // lowest and highest legal blocks
    send_word(ACT_ALLOC, 16'd0);
    send_word(ACT_ALLOC, 16'd8191);
    send_word(ACT_LOOKUP, 16'd8191);
    send_word(ACT_MARK, 16'd8191);
    send_word(ACT_RSVD, 16'd8191);           // spare code behaves as a look-up
    // block already cached: a second entry is taken, searches see the lower one
    send_word(ACT_ALLOC, 16'd0);
    send_word(ACT_LOOKUP, 16'd0);
    send_word(ACT_MARK, 16'd0);
    // alternating bit patterns
    send_word(ACT_ALLOC, 16'h1555);
    send_word(ACT_ALLOC, 16'h0AAA);
    send_word(ACT_LOOKUP, 16'h1555);
    send_word(ACT_MARK, 16'h0AAA);
    send_word(ACT_LOOKUP, 16'h5555);

    // phase one: sender rarely idles, receiver mostly stalls
    repeat (RANDOM_PER_PHASE) send_random_word();
    wait_all_results();

    // phase two: the other way round
    send_idle_pct = 78;
    recv_idle_pct = 7;
    repeat (RANDOM_PER_PHASE) send_random_word();
    wait_all_results();

    // phase three: no idling, opened by a long result stall so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (RANDOM_PER_PHASE) send_random_word();
    wait_all_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d request words: %0d allocations, %0d dirty write-backs",
             words_in, allocs, writebacks);
    $display("%0d misses and %0d out-of-bound requests, under both idling mixes and a long stall",
             misses, out_of_bound);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lbcd_pkg.sv
rtl/core/lbcd_ctrl.sv
rtl/core/lbcd_datapath.sv
rtl/core/lru_buffer_cache_directory.sv
tb/lbcd_checker.sv
tb/lru_buffer_cache_directory_tb.sv
